### design/ntfs_rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run-list decoder package
// Phase codes, decoder state and result types shared by the step logic and
// the top level.
// ----------------------------------------------------------------------------
package ntfs_rld_pkg;

	localparam logic [7:0] NIB_LO = 8'h0F;
	localparam logic [7:0] NIB_HI = 8'hF0;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_COUNT  = 4'b0010,
		PH_DELTA  = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  len_left;
		logic [3:0]  off_left;
		logic [3:0]  pos;
		logic [31:0] cnt;
		logic [31:0] dlt;
		logic [31:0] base;
	} st_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] start_cluster;
		logic [31:0] cluster_count;
		logic        run_valid;
		logic        list_end;
	} res_t;

	localparam st_t ST_RESET = '{
		phase:    PH_HEADER,
		len_left: 4'd0,
		off_left: 4'd0,
		pos:      4'd0,
		cnt:      32'd0,
		dlt:      32'd0,
		base:     32'd0
	};

	// drop the byte into its slot; bytes past the fourth are ignored
	function automatic logic [31:0] place_byte(logic [31:0] acc, logic [3:0] pos,
			logic [7:0] b);
		logic [31:0] r;
		r = acc;
		if (pos[3:2] == 2'b00) begin
			unique case (pos[1:0])
				2'd0: r[7:0]   = b;
				2'd1: r[15:8]  = b;
				2'd2: r[23:16] = b;
				2'd3: r[31:24] = b;
			endcase
		end
		return r;
	endfunction

endpackage

### design/ntfs_rld_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run-list decoder step
// Next-state and result logic for one run-list byte.
// ----------------------------------------------------------------------------
module ntfs_rld_step (
	input  ntfs_rld_pkg::st_t  cur,
	input  logic [7:0]         data_byte,
	input  logic               buffer_last,
	output ntfs_rld_pkg::st_t  nxt,
	output ntfs_rld_pkg::res_t res
);
	import ntfs_rld_pkg::*;

	logic [31:0] cnt_new;
	logic [31:0] dlt_new;
	logic [31:0] dlt_ext;
	logic [31:0] base_new;
	logic [3:0]  len_dec;
	logic [3:0]  off_dec;

	assign cnt_new  = place_byte(cur.cnt, cur.pos, data_byte);
	assign dlt_new  = place_byte(cur.dlt, cur.pos, data_byte);
	assign len_dec  = cur.len_left - 4'd1;
	assign off_dec  = cur.off_left - 4'd1;
	assign base_new = cur.base + dlt_ext;

	// sign-extend short deltas from their top byte
	always_comb begin
		unique case (cur.pos)
			4'd0:    dlt_ext = {{24{dlt_new[7]}}, dlt_new[7:0]};
			4'd1:    dlt_ext = {{16{dlt_new[15]}}, dlt_new[15:0]};
			4'd2:    dlt_ext = {{8{dlt_new[23]}}, dlt_new[23:0]};
			default: dlt_ext = dlt_new;
		endcase
	end

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase)
			PH_HEADER: begin
				if (data_byte == 8'd0) begin
					res.emit     = 1'b1;
					res.list_end = 1'b1;
					nxt.phase    = PH_SKIP;
				end else begin
					nxt.len_left = data_byte[3:0] & NIB_LO[3:0];
					nxt.off_left = 4'((data_byte & NIB_HI) >> 4);
					nxt.pos      = 4'd0;
					nxt.cnt      = 32'd0;
					nxt.dlt      = 32'd0;
					nxt.phase    = (data_byte[3:0] != 4'd0) ? PH_COUNT : PH_DELTA;
				end
			end
			PH_COUNT: begin
				nxt.cnt      = cnt_new;
				nxt.len_left = len_dec;
				nxt.pos      = cur.pos + 4'd1;
				if (len_dec == 4'd0) begin
					nxt.pos = 4'd0;
					if (cur.off_left == 4'd0) begin
						// no delta bytes: sparse run, base holds
						res.emit          = 1'b1;
						res.run_valid     = 1'b1;
						res.cluster_count = cnt_new;
						res.start_cluster = 32'd0;
						nxt               = ST_RESET;
						nxt.base          = cur.base;
					end else begin
						nxt.phase = PH_DELTA;
					end
				end
			end
			PH_DELTA: begin
				nxt.dlt      = dlt_new;
				nxt.off_left = off_dec;
				nxt.pos      = cur.pos + 4'd1;
				if (off_dec == 4'd0) begin
					res.emit          = 1'b1;
					res.run_valid     = 1'b1;
					res.cluster_count = cur.cnt;
					res.start_cluster = (dlt_ext == 32'd0) ? 32'd0 : base_new;
					nxt               = ST_RESET;
					nxt.base          = base_new;
				end
			end
			PH_SKIP: begin
				nxt = cur;
			end
			default: begin
				nxt = ST_RESET;
			end
		endcase

		// buffer end: report the end once and start a fresh list
		if (buffer_last) begin
			if (res.emit) begin
				res.list_end = 1'b1;
			end else if (cur.phase != PH_SKIP) begin
				res.emit     = 1'b1;
				res.list_end = 1'b1;
			end
			nxt = ST_RESET;
		end
	end

endmodule

### design/ntfs_runlist_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTFS run-list decoder core
// Byte-stream decoder that turns an NTFS data-run list into runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one run-list byte per request in s_tdata, s_tlast on
//   the last byte of the buffer. Output stream m_*: one result per completed
//   run, terminator or cut-off buffer; m_tdata = {cluster_count,
//   start_cluster}, m_tuser = run valid, m_tlast = end of list.
// Timing:
//   One byte is decoded per cycle by the step logic while s_tready is high;
//   a result goes to the result register, or to the skid register if that
//   is full. Sustained rate is one byte per cycle while m_tready stays high.
// Stall:
//   A two-entry output buffer (result register plus skid register) keeps
//   s_tready high while one result waits; s_tready drops only when both are
//   full, and no byte is lost or repeated.
// Reset:
//   arst_n clears the decoder to expect a header byte with base cluster 0
//   and empties the output buffer. A buffer-last byte does the same to the
//   decoder state so the next byte starts a new list.
// ----------------------------------------------------------------------------
module ntfs_runlist_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] start_cluster, [63:32] cluster_count
	output logic        m_tuser,   // [0] run_valid
	output logic        m_tlast
);
	import ntfs_rld_pkg::*;

	st_t  st_q;
	st_t  st_nxt;
	res_t res;

	logic        out_vld_q;
	logic [63:0] out_data_q;
	logic        out_user_q;
	logic        out_last_q;
	logic        skd_vld_q;
	logic [63:0] skd_data_q;
	logic        skd_user_q;
	logic        skd_last_q;

	logic accept;
	logic push;
	logic take;

	ntfs_rld_step u_step (
		.cur         (st_q),
		.data_byte   (s_tdata),
		.buffer_last (s_tlast),
		.nxt         (st_nxt),
		.res         (res)
	);

	assign s_tready = ~skd_vld_q;
	assign accept   = s_tvalid & s_tready;
	assign push     = accept & res.emit;
	assign take     = out_vld_q & m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else begin
			if (skd_vld_q) begin
				if (take) begin
					skd_vld_q <= 1'b0;
				end
			end else if (push) begin
				if (out_vld_q && !take) begin
					skd_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b1;
				end
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload: refill from skid first, otherwise load the new result
	always_ff @(posedge clk) begin
		if (skd_vld_q) begin
			if (take) begin
				out_data_q <= skd_data_q;
				out_user_q <= skd_user_q;
				out_last_q <= skd_last_q;
			end
		end else if (push) begin
			if (out_vld_q && !take) begin
				skd_data_q <= {res.cluster_count, res.start_cluster};
				skd_user_q <= res.run_valid;
				skd_last_q <= res.list_end;
			end else begin
				out_data_q <= {res.cluster_count, res.start_cluster};
				out_user_q <= res.run_valid;
				out_last_q <= res.list_end;
			end
		end
	end

endmodule
